// ----- rtl/rrfp_pkg.sv -----
package rrfp_pkg;

	// Frame geometry and header codes
	localparam int unsigned WinBytes  = 9;
	localparam int unsigned FillW     = 4;
	localparam logic [7:0]  HdrType   = 8'hFB;
	localparam logic [7:0]  HdrCode   = 8'h03;
	localparam logic [7:0]  ReportLen = 8'h04;
	localparam logic [15:0] WordOne   = 16'd1;

	// Window byte offsets
	localparam int unsigned OffType  = 0;
	localparam int unsigned OffCode  = 1;
	localparam int unsigned OffBoard = 2;
	localparam int unsigned OffLen   = 3;
	localparam int unsigned OffValid = 4;
	localparam int unsigned OffDist  = 6;
	localparam int unsigned OffCsum  = 8;

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [7:0]  board_id;
		logic [7:0]  payload_length;
		logic        checksum_ok;
		logic        data_valid;
		logic [15:0] distance_dm;
	} rpt_t;

	// Join two payload bytes into a word in the selected order
	function automatic logic [15:0] pair_word(input logic [7:0] first,
		input logic [7:0] second, input logic little);
		logic [15:0] w;
		if (little) begin
			w = {second, first};
		end else begin
			w = {first, second};
		end
		return w;
	endfunction

endpackage

// ----- rtl/rrfp_if.sv -----
// Received serial byte channel
interface rrfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded report channel
interface rrfp_rpt_if;
	logic        valid;
	logic        ready;
	logic [7:0]  board_id;
	logic [7:0]  payload_length;
	logic        checksum_ok;
	logic        data_valid;
	logic [15:0] distance_dm;

	modport source (output valid, output board_id, output payload_length,
		output checksum_ok, output data_valid, output distance_dm, input ready);
	modport sink (input valid, input board_id, input payload_length,
		input checksum_ok, input data_valid, input distance_dm, output ready);
endinterface

// Configuration write channel
interface rrfp_cfg_if;
	logic valid;
	logic ready;
	logic payload_little_endian;

	modport source (output valid, output payload_little_endian, input ready);
	modport sink (input valid, input payload_little_endian, output ready);
endinterface

// ----- rtl/range_report_frame_parser.sv -----
// Range report frame parser. Serial bytes enter a 9-byte sliding window; once
// nine bytes have arrived, every new byte checks the window for the header
// 0xFB 0x03 and a match produces one report word (board id, length, checksum
// flag, valid flag, distance). A byte can be taken every cycle unless the input
// stalls: the window register feeds combinational decode logic (header compare,
// 8-byte checksum adder tree, word assembly) into the report register, which
// holds the report decoded from the byte that completes it. Input stalls only
// while a decoded report waits in the window stage behind an unread report in
// the output register. payload_little_endian (reset 1) selects the byte order
// of the payload words; write it only while the parser is idle.
module range_report_frame_parser
	import rrfp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rrfp_byte_if.sink    rx,
	rrfp_rpt_if.source   rpt,
	rrfp_cfg_if.sink     cfg
);

	byte_t            win_s1 [WinBytes];
	logic             chk_s1;
	logic [FillW-1:0] fill_q;
	logic             little_q;
	logic             out_valid_q;
	rpt_t             out_q;

	logic             hdr_match;
	logic             stall;
	logic             out_load;
	logic             rx_acc;
	logic [7:0]       sum;
	rpt_t             rpt_next;

	// Config register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			little_q <= 1'b1;
		end else if (cfg.valid) begin
			little_q <= cfg.payload_little_endian;
		end
	end

	// Flow control
	assign hdr_match = chk_s1 && (win_s1[OffType] == HdrType) && (win_s1[OffCode] == HdrCode);
	assign stall     = hdr_match && out_valid_q && !rpt.ready;
	assign out_load  = hdr_match && !stall;
	assign rx.ready  = !stall;
	assign rx_acc    = rx.valid && rx.ready;

	// Byte window: oldest at offset 0, new byte enters at the top
	always_ff @(posedge clk) begin
		if (rx_acc) begin
			for (int i = 0; i < WinBytes - 1; i++) begin
				win_s1[i] <= win_s1[i+1];
			end
			win_s1[WinBytes-1] <= rx.rx_byte;
		end
	end

	// Fill count and check flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			chk_s1 <= 1'b0;
		end else if (rx_acc) begin
			if (fill_q != FillW'(WinBytes)) begin
				fill_q <= fill_q + FillW'(1);
			end
			chk_s1 <= (fill_q >= FillW'(WinBytes - 1));
		end else if (!stall) begin
			chk_s1 <= 1'b0;
		end
	end

	// Decode: checksum tree and payload words
	always_comb begin
		sum = ((win_s1[0] + win_s1[1]) + (win_s1[2] + win_s1[3]))
			+ ((win_s1[4] + win_s1[5]) + (win_s1[6] + win_s1[7]));
		rpt_next.board_id       = win_s1[OffBoard];
		rpt_next.payload_length = win_s1[OffLen];
		rpt_next.checksum_ok    = 1'b0;
		rpt_next.data_valid     = 1'b0;
		rpt_next.distance_dm    = '0;
		if (win_s1[OffLen] == ReportLen) begin
			rpt_next.checksum_ok = (sum == win_s1[OffCsum]);
			rpt_next.data_valid  =
				(pair_word(win_s1[OffValid], win_s1[OffValid+1], little_q) == WordOne);
			rpt_next.distance_dm = pair_word(win_s1[OffDist], win_s1[OffDist+1], little_q);
		end
	end

	// Report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rpt.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= rpt_next;
		end
	end

	assign rpt.valid          = out_valid_q;
	assign rpt.board_id       = out_q.board_id;
	assign rpt.payload_length = out_q.payload_length;
	assign rpt.checksum_ok    = out_q.checksum_ok;
	assign rpt.data_valid     = out_q.data_valid;
	assign rpt.distance_dm    = out_q.distance_dm;

	// Checks
	a_chk_full: assert property (@(posedge clk) disable iff (!arst_n)
		chk_s1 |-> fill_q == FillW'(WinBytes))
		else $error("window checked before full");

	a_new_rpt: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(hdr_match))
		else $error("report without header match");

	a_len_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.checksum_ok || out_q.data_valid) |->
		out_q.payload_length == ReportLen)
		else $error("flags set for wrong length");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> hdr_match)
		else $error("stalled report lost");

endmodule
